>>> rtl/stoch_pkg.sv
package stoch_pkg;

    // Sizes of the block
    localparam int MAX_K_PERIOD = 64;
    localparam int MAX_D_PERIOD = 64;
    localparam int SLOWING_BARS = 3;
    localparam int PRICE_BITS   = 32;

    // Period registers
    localparam int PERIOD_W  = 7;
    localparam int DEFAULT_K = 5;
    localparam int DEFAULT_D = 3;
    localparam int DEF_K_EFF = (DEFAULT_K > MAX_K_PERIOD) ? MAX_K_PERIOD : DEFAULT_K;
    localparam int DEF_D_EFF = (DEFAULT_D > MAX_D_PERIOD) ? MAX_D_PERIOD : DEFAULT_D;
    localparam int PCMP_W    = 10;

    // Config port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PERIOD_W;
    localparam logic [CFG_ADDR_W-1:0] REG_K_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_D_PERIOD = 1'd1;

    // Counters and pointers
    localparam int KP_W   = $clog2(MAX_K_PERIOD + 1);
    localparam int RPTR_W = $clog2(MAX_K_PERIOD);
    localparam int DP_W   = $clog2(MAX_D_PERIOD + 1);
    localparam int KPTR_W = $clog2(MAX_D_PERIOD);
    localparam int SCNT_W = $clog2(SLOWING_BARS + 1);
    localparam int SPTR_W = (SLOWING_BARS > 1) ? $clog2(SLOWING_BARS) : 1;

    // Arithmetic widths
    localparam int DIFF_W  = PRICE_BITS + 1;
    localparam int SUM_W   = DIFF_W + $clog2(SLOWING_BARS);
    localparam int MAG_W   = SUM_W - 1;
    localparam int KVAL_W  = 23;
    localparam int DSUM_W  = KVAL_W + $clog2(MAX_D_PERIOD);
    localparam int DVD_W   = MAG_W + KVAL_W;
    localparam logic [KVAL_W-1:0] FULL_SCALE = 23'd6553600;

    // Stream packing
    localparam int IN_DATA_W  = ((3 * PRICE_BITS + 7) / 8) * 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = ((2 * KVAL_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic slow;
        logic sum;
        logic mag;
        logic kdiv_start;
        logic kwrite;
        logic dsum;
        logic ddiv_start;
        logic out_load;
    } stoch_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic slow_go;
        logic div_busy;
        logic d_go;
        logic dsum_done;
        logic out_free;
    } stoch_sts_t;

endpackage

>>> rtl/stoch_div.sv
module stoch_div import stoch_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [MAG_W-1:0]  divisor,
    output logic              busy,
    output logic [KVAL_W-1:0] quotient
);

    localparam int REM_W = DVD_W - KVAL_W;
    localparam int CNT_W = $clog2(KVAL_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [KVAL_W-1:0] shf_reg;
    logic [MAG_W-1:0] dvs_reg;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, shf_reg[KVAL_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(KVAL_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and shift register; low bits turn into the quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DVD_W-1:KVAL_W];
            shf_reg <= dividend[KVAL_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[KVAL_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = shf_reg;

endmodule

>>> rtl/stoch_datapath.sv
module stoch_datapath import stoch_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  stoch_cmd_t            cmd,
    output stoch_sts_t            sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    // Input fields
    logic [PRICE_BITS-1:0] hi_in, lo_in, cl_in;
    logic                  new_in;

    assign hi_in  = s_tdata[PRICE_BITS-1:0];
    assign lo_in  = s_tdata[2*PRICE_BITS-1:PRICE_BITS];
    assign cl_in  = s_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
    assign new_in = s_tuser[0];

    // Config and effective periods
    logic [PERIOD_W-1:0] k_period_reg, d_period_reg;
    logic [KP_W-1:0]     kp;
    logic [DP_W-1:0]     dp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_period_reg <= PERIOD_W'(DEFAULT_K);
            d_period_reg <= PERIOD_W'(DEFAULT_D);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_K_PERIOD: k_period_reg <= cfg_wdata;
                REG_D_PERIOD: d_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (k_period_reg == '0) begin
            kp = KP_W'(DEF_K_EFF);
        end else if (PCMP_W'(k_period_reg) > PCMP_W'(MAX_K_PERIOD)) begin
            kp = KP_W'(MAX_K_PERIOD);
        end else begin
            kp = KP_W'(k_period_reg);
        end
        if (d_period_reg == '0) begin
            dp = DP_W'(DEF_D_EFF);
        end else if (PCMP_W'(d_period_reg) > PCMP_W'(MAX_D_PERIOD)) begin
            dp = DP_W'(MAX_D_PERIOD);
        end else begin
            dp = DP_W'(d_period_reg);
        end
    end

    // Control state
    logic [KP_W-1:0]   bar_reg;
    logic [KP_W-1:0]   bar_base;
    logic [RPTR_W-1:0] rptr_reg;
    logic [KP_W-1:0]   scnt_reg;
    logic              rd_vld_reg;
    logic [SCNT_W-1:0] slow_cnt_reg;
    logic [SPTR_W-1:0] sptr_reg;
    logic [DP_W-1:0]   k_cnt_reg;
    logic [DP_W-1:0]   k_cnt_next;
    logic [KPTR_W-1:0] kptr_reg;
    logic [DP_W-1:0]   dcnt_reg;
    logic              drd_vld_reg;
    logic              kvalid_reg;
    logic              dvalid_reg;
    logic              m_tvalid_reg;

    // Payload
    logic [PRICE_BITS-1:0] cl_reg, hh_reg, ll_reg;
    logic [PRICE_BITS-1:0] hi_rd_reg, lo_rd_reg;
    logic [PRICE_BITS-1:0] high_mem [MAX_K_PERIOD];
    logic [PRICE_BITS-1:0] low_mem  [MAX_K_PERIOD];
    logic [DIFF_W-1:0]     cml_reg  [SLOWING_BARS];
    logic [DIFF_W-1:0]     rng_reg  [SLOWING_BARS];
    logic [SUM_W-1:0]      s1_reg, s2_reg, s1_sum, s2_sum;
    logic [MAG_W-1:0]      a_reg, b_reg;
    logic                  den_zero_reg, zero_opp_reg;
    logic [KVAL_W-1:0]     kval_reg, kval_new, k_rd_reg;
    logic [KVAL_W-1:0]     k_mem [MAX_D_PERIOD];
    logic [DSUM_W-1:0]     dsum_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    // Window scan addressing
    logic              win_ok;
    logic              scan_issue;
    logic [KP_W:0]     scan_diff;
    logic [RPTR_W-1:0] scan_addr;

    assign win_ok     = (bar_reg >= kp);
    assign scan_issue = cmd.scan && win_ok && (scnt_reg < kp);

    always_comb begin
        scan_diff = (KP_W+1)'(rptr_reg) - (KP_W+1)'(scnt_reg);
        if (scan_diff[KP_W]) begin
            scan_diff = scan_diff + (KP_W+1)'(MAX_K_PERIOD);
        end
        scan_addr = scan_diff[RPTR_W-1:0];
    end

    // %D scan addressing: newest K first, going back
    logic              d_issue;
    logic [DP_W:0]     d_diff;
    logic [KPTR_W-1:0] d_addr;

    assign d_issue = cmd.dsum && (dcnt_reg < dp);

    always_comb begin
        d_diff = (DP_W+1)'(kptr_reg) - (DP_W+1)'(dcnt_reg) - (DP_W+1)'(1);
        if (d_diff[DP_W]) begin
            d_diff = d_diff + (DP_W+1)'(MAX_D_PERIOD);
        end
        d_addr = d_diff[KPTR_W-1:0];
    end

    // Slowing sums
    always_comb begin
        s1_sum = '0;
        s2_sum = '0;
        for (int i = 0; i < SLOWING_BARS; i++) begin
            s1_sum = s1_sum + SUM_W'($signed(cml_reg[i]));
            s2_sum = s2_sum + SUM_W'($signed(rng_reg[i]));
        end
    end

    // Shared divider
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [MAG_W-1:0]  div_dvs;
    logic              div_busy;
    logic [KVAL_W-1:0] div_q;

    assign div_start = cmd.kdiv_start || cmd.ddiv_start;

    always_comb begin
        if (cmd.kdiv_start) begin
            div_dvd = DVD_W'(a_reg) * DVD_W'(FULL_SCALE);
            div_dvs = b_reg;
        end else begin
            div_dvd = DVD_W'(dsum_reg);
            div_dvs = MAG_W'(dp);
        end
    end

    stoch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // %K with flat-range and out-of-range cases
    always_comb begin
        if (den_zero_reg) begin
            kval_new = FULL_SCALE;
        end else if (zero_opp_reg) begin
            kval_new = '0;
        end else if (a_reg >= b_reg) begin
            kval_new = FULL_SCALE;
        end else begin
            kval_new = div_q;
        end
    end

    assign bar_base   = new_in ? '0 : bar_reg;
    assign k_cnt_next = (k_cnt_reg == DP_W'(MAX_D_PERIOD)) ? k_cnt_reg : k_cnt_reg + DP_W'(1);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_reg      <= '0;
            rptr_reg     <= '0;
            scnt_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            slow_cnt_reg <= '0;
            sptr_reg     <= '0;
            k_cnt_reg    <= '0;
            kptr_reg     <= '0;
            dcnt_reg     <= '0;
            drd_vld_reg  <= 1'b0;
            kvalid_reg   <= 1'b0;
            dvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= scan_issue;
            drd_vld_reg <= d_issue;
            if (cmd.load) begin
                bar_reg    <= (bar_base == KP_W'(MAX_K_PERIOD)) ? bar_base
                                                               : bar_base + KP_W'(1);
                scnt_reg   <= KP_W'(1);
                kvalid_reg <= 1'b0;
                dvalid_reg <= 1'b0;
                if (new_in) begin
                    slow_cnt_reg <= '0;
                    k_cnt_reg    <= '0;
                end
            end
            if (scan_issue) begin
                scnt_reg <= scnt_reg + KP_W'(1);
            end
            if (cmd.slow) begin
                if (!win_ok) begin
                    slow_cnt_reg <= '0;
                end else if (slow_cnt_reg != SCNT_W'(SLOWING_BARS)) begin
                    slow_cnt_reg <= slow_cnt_reg + SCNT_W'(1);
                end
                sptr_reg <= (sptr_reg == SPTR_W'(SLOWING_BARS - 1)) ? '0
                                                                    : sptr_reg + SPTR_W'(1);
                rptr_reg <= (rptr_reg == RPTR_W'(MAX_K_PERIOD - 1)) ? '0
                                                                    : rptr_reg + RPTR_W'(1);
                if (!sts.slow_go) begin
                    k_cnt_reg <= '0;
                end
            end
            if (cmd.kwrite) begin
                kvalid_reg <= 1'b1;
                k_cnt_reg  <= k_cnt_next;
                kptr_reg   <= (kptr_reg == KPTR_W'(MAX_D_PERIOD - 1)) ? '0
                                                                      : kptr_reg + KPTR_W'(1);
                dcnt_reg   <= '0;
            end
            if (d_issue) begin
                dcnt_reg <= dcnt_reg + DP_W'(1);
            end
            if (cmd.ddiv_start) begin
                dvalid_reg <= 1'b1;
            end
            // Output register
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Bar memories, window max/min
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cl_reg             <= cl_in;
            hh_reg             <= hi_in;
            ll_reg             <= lo_in;
            high_mem[rptr_reg] <= hi_in;
            low_mem[rptr_reg]  <= lo_in;
        end else if (rd_vld_reg) begin
            if (hi_rd_reg > hh_reg) begin
                hh_reg <= hi_rd_reg;
            end
            if (lo_rd_reg < ll_reg) begin
                ll_reg <= lo_rd_reg;
            end
        end
        if (scan_issue) begin
            hi_rd_reg <= high_mem[scan_addr];
            lo_rd_reg <= low_mem[scan_addr];
        end
    end

    // Slowing history, sums and magnitudes
    always_ff @(posedge aclk) begin
        if (cmd.slow) begin
            if (win_ok) begin
                cml_reg[sptr_reg] <= DIFF_W'(cl_reg) - DIFF_W'(ll_reg);
                rng_reg[sptr_reg] <= DIFF_W'(hh_reg) - DIFF_W'(ll_reg);
            end else begin
                cml_reg[sptr_reg] <= '0;
                rng_reg[sptr_reg] <= '0;
            end
        end
        if (cmd.sum) begin
            s1_reg <= s1_sum;
            s2_reg <= s2_sum;
        end
        if (cmd.mag) begin
            a_reg        <= s1_reg[SUM_W-1] ? MAG_W'(-s1_reg) : MAG_W'(s1_reg);
            b_reg        <= s2_reg[SUM_W-1] ? MAG_W'(-s2_reg) : MAG_W'(s2_reg);
            den_zero_reg <= (s2_reg == '0);
            zero_opp_reg <= (s1_reg == '0) || (s1_reg[SUM_W-1] != s2_reg[SUM_W-1]);
        end
    end

    // K memory and %D sum
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kval_reg <= '0;
        end
        if (cmd.kwrite) begin
            kval_reg         <= kval_new;
            k_mem[kptr_reg]  <= kval_new;
            dsum_reg         <= '0;
        end else if (drd_vld_reg) begin
            dsum_reg <= dsum_reg + DSUM_W'(k_rd_reg);
        end
        if (d_issue) begin
            k_rd_reg <= k_mem[d_addr];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_DATA_W'({(dvalid_reg ? div_q : KVAL_W'(0)), kval_reg});
            m_tuser_reg <= {dvalid_reg, kvalid_reg};
        end
    end

    // Status
    always_comb begin
        sts.scan_done = !rd_vld_reg && !(win_ok && (scnt_reg < kp));
        sts.slow_go   = win_ok && (slow_cnt_reg >= SCNT_W'(SLOWING_BARS - 1));
        sts.div_busy  = div_busy;
        sts.d_go      = (k_cnt_next >= dp);
        sts.dsum_done = !drd_vld_reg && (dcnt_reg >= dp);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/stoch_ctrl.sv
module stoch_ctrl import stoch_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  stoch_sts_t sts,
    output stoch_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'h001,
        ST_SCAN    = 12'h002,
        ST_SLOW    = 12'h004,
        ST_SUM     = 12'h008,
        ST_MAG     = 12'h010,
        ST_KDIV_GO = 12'h020,
        ST_KDIV    = 12'h040,
        ST_KWRITE  = 12'h080,
        ST_DSUM    = 12'h100,
        ST_DDIV_GO = 12'h200,
        ST_DDIV    = 12'h400,
        ST_OUT     = 12'h800
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_SLOW;
                end
            end
            ST_SLOW: begin
                cmd.slow   = 1'b1;
                state_next = sts.slow_go ? ST_SUM : ST_OUT;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_KDIV_GO;
            end
            ST_KDIV_GO: begin
                cmd.kdiv_start = 1'b1;
                state_next     = ST_KDIV;
            end
            ST_KDIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_KWRITE;
                end
            end
            ST_KWRITE: begin
                cmd.kwrite = 1'b1;
                state_next = sts.d_go ? ST_DSUM : ST_OUT;
            end
            ST_DSUM: begin
                cmd.dsum = 1'b1;
                if (sts.dsum_done) begin
                    state_next = ST_DDIV_GO;
                end
            end
            ST_DDIV_GO: begin
                cmd.ddiv_start = 1'b1;
                state_next     = ST_DDIV;
            end
            ST_DDIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/stochastic_oscillator.sv
// From bar transfer to registered result: before the k_period window fills no scan or
// division is done; while slowing warms up only the window scan; with %K valid also a
// divider pass, and with %D valid also the %K memory scan and a second divider pass.
// One bar at a time: the next bar is taken in the cycle after its result is registered;
// the window scan, the %K memory scan and the shared divider's 23-step passes run in between.
// Synchronous active-low reset: periods 5 and 3, history counts cleared, memories kept.
module stochastic_oscillator import stoch_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // high_price, low_price, close_price
    input  logic [IN_USER_W-1:0]  s_tuser,   // new_series
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // k_value, d_value, zero pad
    output logic [OUT_USER_W-1:0] m_tuser,   // k_valid, d_valid
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    stoch_cmd_t cmd;
    stoch_sts_t sts;

    stoch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stoch_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/stoch_checker.sv
module stoch_checker import stoch_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No %K means no values and no %D
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[KVAL_W-1:0] == '0) &&
            (m_tdata[2*KVAL_W-1:KVAL_W] == '0) && !m_tuser[1])
        else $error("invalid K carries data");

    // Percent values stay within full scale
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[KVAL_W-1:0] <= FULL_SCALE) &&
            (m_tdata[2*KVAL_W-1:KVAL_W] <= FULL_SCALE))
        else $error("percent above full scale");

    // One bar in flight: ready drops after a transfer
    a_one_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second bar taken while busy");

    // Reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stochastic_oscillator stoch_checker u_stoch_checker (.*);

>>> dv/stochastic_oscillator_tb.sv
module stochastic_oscillator_tb import stoch_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;

    // One %K / %D result as it leaves the block
    typedef struct {
        logic [KVAL_W-1:0] k_value;
        logic              k_valid;
        logic [KVAL_W-1:0] d_value;
        logic              d_valid;
    } kd_result_t;

    // Tracks the oscillator state and holds the %K/%D values still owed by the block
    class stoch_scoreboard;
        logic [PERIOD_W-1:0] k_reg;
        logic [PERIOD_W-1:0] d_reg;
        longint              hi_hist[MAX_K_PERIOD];
        longint              lo_hist[MAX_K_PERIOD];
        longint              close_off[SLOWING_BARS];
        longint              range_off[SLOWING_BARS];
        logic [KVAL_W-1:0]   k_hist[MAX_D_PERIOD];
        int                  bars_in_series;
        int                  bar_slot;
        int                  slow_slot;
        int                  slow_bars;
        int                  k_slot;
        int                  k_run;
        int                  errors;
        kd_result_t          pending_kd[$];

        function new();
            k_reg          = PERIOD_W'(DEFAULT_K);
            d_reg          = PERIOD_W'(DEFAULT_D);
            bars_in_series = 0;
            bar_slot       = 0;
            slow_slot      = 0;
            slow_bars      = 0;
            k_slot         = 0;
            k_run          = 0;
            errors         = 0;
        endfunction

        function void set_periods(logic [PERIOD_W-1:0] k, logic [PERIOD_W-1:0] d);
            k_reg = k;
            d_reg = d;
        endfunction

        // Zero selects the default, anything past the depth clips to it
        function int period_in_use(logic [PERIOD_W-1:0] r, int dflt, int maxv);
            int p;
            p = int'(r);
            if (p == 0) p = dflt;
            if (p > maxv) p = maxv;
            return p;
        endfunction

        // Work out the result one accepted bar will produce
        function void note_bar(logic [IN_DATA_W-1:0] data, logic [IN_USER_W-1:0] user);
            int          kp;
            int          dp;
            int          idx;
            longint      hi_v;
            longint      lo_v;
            longint      cl_v;
            longint      hh;
            longint      ll;
            longint      s1;
            longint      s2;
            longint unsigned a;
            longint unsigned b;
            int unsigned d_sum;
            kd_result_t  res;

            kp   = period_in_use(k_reg, DEFAULT_K, MAX_K_PERIOD);
            dp   = period_in_use(d_reg, DEFAULT_D, MAX_D_PERIOD);
            hi_v = {32'd0, data[31:0]};
            lo_v = {32'd0, data[63:32]};
            cl_v = {32'd0, data[95:64]};
            res  = '{k_value: '0, k_valid: 1'b0, d_value: '0, d_valid: 1'b0};

            if (user[0]) begin
                bars_in_series = 0;
                slow_bars      = 0;
                k_run          = 0;
            end

            hi_hist[bar_slot] = hi_v;
            lo_hist[bar_slot] = lo_v;
            if (bars_in_series < MAX_K_PERIOD) bars_in_series++;

            // Highest high and lowest low over the window, then the slowing terms
            if (bars_in_series >= kp) begin
                hh = hi_v;
                ll = lo_v;
                for (int i = 1; i < kp; i++) begin
                    idx = (bar_slot + MAX_K_PERIOD - i) % MAX_K_PERIOD;
                    if (hi_hist[idx] > hh) hh = hi_hist[idx];
                    if (lo_hist[idx] < ll) ll = lo_hist[idx];
                end
                close_off[slow_slot] = cl_v - ll;
                range_off[slow_slot] = hh - ll;
                if (slow_bars < SLOWING_BARS) slow_bars++;
            end else begin
                close_off[slow_slot] = 0;
                range_off[slow_slot] = 0;
                slow_bars            = 0;
            end
            slow_slot = (slow_slot + 1) % SLOWING_BARS;
            bar_slot  = (bar_slot + 1) % MAX_K_PERIOD;

            if (slow_bars >= SLOWING_BARS) begin
                s1 = 0;
                s2 = 0;
                for (int i = 0; i < SLOWING_BARS; i++) begin
                    s1 += close_off[i];
                    s2 += range_off[i];
                end
                // Flat range is full scale; opposite signs or zero give 0; ratio capped at 1
                if (s2 == 0) begin
                    res.k_value = FULL_SCALE;
                end else if (s1 == 0 || ((s1 < 0) != (s2 < 0))) begin
                    res.k_value = '0;
                end else begin
                    a = (s1 < 0) ? longint'(-s1) : s1;
                    b = (s2 < 0) ? longint'(-s2) : s2;
                    if (a >= b) res.k_value = FULL_SCALE;
                    else res.k_value = KVAL_W'((a * 64'd6553600) / b);
                end
                res.k_valid    = 1'b1;
                k_hist[k_slot] = res.k_value;
                if (k_run < MAX_D_PERIOD) k_run++;
                if (k_run >= dp) begin
                    d_sum = 0;
                    for (int i = 0; i < dp; i++)
                        d_sum += k_hist[(k_slot + MAX_D_PERIOD - i) % MAX_D_PERIOD];
                    res.d_value = KVAL_W'(d_sum / dp);
                    res.d_valid = 1'b1;
                end
                k_slot = (k_slot + 1) % MAX_D_PERIOD;
            end else begin
                k_run = 0;
            end

            pending_kd.push_back(res);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        // Compare one result transfer with the oldest expected %K/%D
        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            kd_result_t want;
            if (pending_kd.size() == 0) begin
                report($sformatf("result %h/%h with none expected", data, user));
                return;
            end
            want = pending_kd.pop_front();
            if (data[KVAL_W-1:0] !== want.k_value)
                report($sformatf("k_value %0d, want %0d", data[KVAL_W-1:0], want.k_value));
            if (user[0] !== want.k_valid)
                report($sformatf("k_valid %b, want %b", user[0], want.k_valid));
            if (data[2*KVAL_W-1:KVAL_W] !== want.d_value)
                report($sformatf("d_value %0d, want %0d",
                                 data[2*KVAL_W-1:KVAL_W], want.d_value));
            if (user[1] !== want.d_valid)
                report($sformatf("d_valid %b, want %b", user[1], want.d_valid));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // high_price, low_price, close_price
    logic [IN_USER_W-1:0]  s_tuser   = '0;   // new_series
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // k_value, d_value, zero pad
    logic [OUT_USER_W-1:0] m_tuser;          // k_valid, d_valid
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    int     hold_asks    = 0;
    int     hold_taken   = 0;
    int     hold_left    = 0;
    longint walk_price   = 64'd100_000;

    stoch_scoreboard sb = new();

    stochastic_oscillator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("stochastic_oscillator regression: fail");
        $finish;
    end

    // Input transfers feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_bar(s_tdata, s_tuser);
    end

    // Output transfers are checked
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            hold_taken <= hold_asks;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic longint clip_price(longint v);
        if (v < 0) return 0;
        if (v > PRICE_MAX) return PRICE_MAX;
        return v;
    endfunction

    // Offer one bar, with a random idle gap ahead of it, and wait for its transfer
    task automatic send_bar(input logic [31:0] h, input logic [31:0] l,
                            input logic [31:0] c, input logic ns);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tdata  <= {c, l, h};
        s_tuser  <= ns;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and let every expected result come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_kd.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_periods(input logic [PERIOD_W-1:0] k, input logic [PERIOD_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_K_PERIOD;
        cfg_wdata <= k;
        @(posedge aclk);
        cfg_addr  <= REG_D_PERIOD;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.set_periods(k, d);
    endtask

    // Mostly well-formed bars around a wandering price, some noise and rail values
    task automatic random_bar(output logic [31:0] h, output logic [31:0] l,
                              output logic [31:0] c);
        int unsigned spread;
        int          pick;
        longint      lo_v;
        longint      hi_v;
        pick = $urandom_range(99);
        if (pick < 10) begin
            h = $urandom;
            l = $urandom;
            c = $urandom;
        end else if (pick < 14) begin
            h = $urandom_range(1) ? '1 : '0;
            l = $urandom_range(1) ? '1 : '0;
            c = $urandom_range(1) ? '1 : '0;
        end else begin
            if ($urandom_range(49) == 0) walk_price = {32'd0, $urandom};
            walk_price = clip_price(walk_price + longint'($urandom_range(2000)) - 1000);
            case ($urandom_range(3))
                0: spread = 3;
                1: spread = 1000;
                2: spread = 1_000_000;
                default: spread = $urandom;
            endcase
            lo_v = clip_price(walk_price - longint'($urandom_range(spread)));
            hi_v = clip_price(walk_price + longint'($urandom_range(spread)));
            l = lo_v[31:0];
            h = hi_v[31:0];
            c = 32'(lo_v + longint'({32'd0, $urandom}) % (hi_v - lo_v + 1));
        end
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] k, input logic [PERIOD_W-1:0] d,
                             input int tx_pct, input int rx_pct, input int bars,
                             input int ns_per_mille, input bit pressure);
        logic [31:0] h;
        logic [31:0] l;
        logic [31:0] c;
        wait_idle();
        set_periods(k, d);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        for (int i = 0; i < bars; i++) begin
            if (pressure && i == bars / 3) hold_asks <= hold_asks + 1;
            if (pressure && i == (2 * bars) / 3) wait_idle();
            random_bar(h, l, c);
            send_bar(h, l, c, $urandom_range(999) < ns_per_mille);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bars at the reset periods: zero history gives a flat range
        for (int i = 0; i < 9; i++) send_bar(32'd0, 32'd0, 32'd0, i == 0);
        // Close at the top and bottom of a full-scale range
        send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
        // Inconsistent bars: high below low, close above high, close below low
        send_bar(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_bar(32'd100, 32'd50, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFF0, 32'hFFFF_FF00, 32'd0, 1'b0);
        // Ordinary bars, then a series restart mid-stream
        send_bar(32'd1200, 32'd1000, 32'd1100, 1'b0);
        send_bar(32'd1300, 32'd1050, 32'd1290, 1'b0);
        send_bar(32'd1250, 32'd900, 32'd950, 1'b0);
        send_bar(32'd1400, 32'd1100, 32'd1350, 1'b0);
        send_bar(32'd5000, 32'd4000, 32'd4500, 1'b1);
        // All-ones flat bars in the new series
        for (int i = 0; i < 8; i++) send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        // Random phases over several period settings and idling patterns
        run_phase(7'd1,   7'd1,  0,  0,  60, 20, 1'b0);
        run_phase(7'd64,  7'd64, 33, 33, 150, 0, 1'b0);
        run_phase(7'd0,   7'd0,  75, 0,  60, 30, 1'b0);
        run_phase(7'd127, 7'd65, 0,  75, 140, 0, 1'b1);
        run_phase(PERIOD_W'($urandom_range(12, 1)), PERIOD_W'($urandom_range(12, 1)),
                  33, 33, 60, 30, 1'b0);
        run_phase(7'd2,   7'd7,  0,  0,  40, 20, 1'b0);
        run_phase(7'd5,   7'd3,  33, 33, 30, 20, 1'b0);

        wait_idle();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_kd.size() == 0) begin
            $display("stochastic_oscillator regression: pass");
        end else begin
            $display("stochastic_oscillator regression: fail");
        end
        $finish;
    end

endmodule
